// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Included by bare file name; holds nothing but these definitions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CHK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/crcdf_pkg.sv =====
// Types, constants and helper functions of the CRC block deframer.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package crcdf_pkg;

  // Record header layout.
  localparam int unsigned HEADER_BYTES = 9;
  localparam int unsigned HDR_CNT_W    = 4;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST  = 4'd8;
  localparam logic [HDR_CNT_W-1:0] FLAGS_POS = 4'd4;
  localparam logic [HDR_CNT_W-1:0] CRC_POS   = 4'd5;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Record status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CRC   = 2'd1,
    ST_TRUNC_HDR = 2'd2,
    ST_TRUNC_PAY = 2'd3
  } status_t;

  // Parser phase.
  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  // Operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,  // a record with payload begins
    OP_REPORT = 2'd1,  // a status-only report, no payload byte
    OP_PAY    = 2'd2   // one payload byte
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        last;    // final payload byte of the record
    logic        trunc;   // buffer ended on this payload byte
    status_t     status;  // for reports
    logic [7:0]  flags;
    logic [31:0] length;
    logic [31:0] crc;     // stored CRC, for record start
  } op_t;

  // Configuration seen by the front.
  typedef struct packed {
    logic valid;
    logic data;
  } cfg_t;

  // One byte step of the reflected CRC-32.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Place one header byte into a 32-bit word.
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [7:0] b,
                                           input logic big, input logic [1:0] lane);
    logic [31:0] r;
    if (big) begin
      r = {word[23:0], b};
    end else begin
      r = word | ({24'd0, b} << {lane, 3'b000});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/crcdf_queue.sv =====
// Short queue of operations between the deframer front and back.
// Depends on crcdf_pkg for the operation type.
`timescale 1ns / 1ps
`default_nettype none

module crcdf_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire crcdf_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output crcdf_pkg::op_t     head_op,
  output logic               not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crcdf_pkg::op_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_op   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/crcdf_front.sv =====
// Front of the deframer: parses record headers from the bytes, counts payload
// and hands payload bytes, ended headers and truncations to the back. Uses crcdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcdf_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crcdf_pkg::cfg_t cfg,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        buffer_end,
  output logic             push,
  output crcdf_pkg::op_t   push_op
);

  crcdf_pkg::phase_t                    phase;
  crcdf_pkg::phase_t                    phase_next;
  logic                                 byte_order;
  logic [crcdf_pkg::HDR_CNT_W-1:0]      header_count;
  logic [31:0]                          length_word;
  logic [7:0]                           flags_byte;
  logic [31:0]                          expected_crc;
  logic [31:0]                          bytes_remaining;

  logic [crcdf_pkg::HDR_CNT_W-1:0]      idx;
  logic [31:0]                          len_base;
  logic [31:0]                          crc_base;
  logic [7:0]                           flags_base;
  logic [31:0]                          len_new;
  logic [31:0]                          crc_new;
  logic [7:0]                           flags_new;
  logic [crcdf_pkg::HDR_CNT_W-1:0]      crc_off;
  logic                                 hdr_done;
  logic                                 pay_last;
  logic                                 rec_end;

  // Header byte placement.
  always_comb begin
    idx        = (header_count > crcdf_pkg::HDR_LAST) ? '0 : header_count;
    len_base   = (idx == '0) ? '0 : length_word;
    crc_base   = (idx == '0) ? '0 : expected_crc;
    flags_base = (idx == '0) ? '0 : flags_byte;
    crc_off    = idx - crcdf_pkg::CRC_POS;
    len_new    = len_base;
    crc_new    = crc_base;
    flags_new  = flags_base;
    if (idx < crcdf_pkg::FLAGS_POS) begin
      len_new = crcdf_pkg::put_byte(len_base, data_byte, byte_order, idx[1:0]);
    end else if (idx == crcdf_pkg::FLAGS_POS) begin
      flags_new = data_byte;
    end else begin
      crc_new = crcdf_pkg::put_byte(crc_base, data_byte, byte_order, crc_off[1:0]);
    end
    hdr_done = (idx == crcdf_pkg::HDR_LAST);
    pay_last = (bytes_remaining == 32'd1);
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        crcdf_pkg::PH_HEADER: begin
          if (hdr_done && len_new != '0 && !buffer_end) begin
            phase_next = crcdf_pkg::PH_PAYLOAD;
          end
        end
        crcdf_pkg::PH_PAYLOAD: begin
          if (pay_last || buffer_end) begin
            phase_next = crcdf_pkg::PH_HEADER;
          end
        end
        default: phase_next = crcdf_pkg::PH_HEADER;
      endcase
    end
  end

  // Operation for the back.
  always_comb begin
    push    = 1'b0;
    push_op = '0;
    rec_end = 1'b0;
    unique case (phase)
      crcdf_pkg::PH_HEADER: begin
        if (hdr_done) begin
          push           = accept;
          push_op.flags  = flags_new;
          push_op.length = len_new;
          push_op.crc    = crc_new;
          if (len_new == '0) begin
            push_op.kind   = crcdf_pkg::OP_REPORT;
            push_op.status = (crc_new == '0) ? crcdf_pkg::ST_OK : crcdf_pkg::ST_BAD_CRC;
            rec_end        = 1'b1;
          end else if (buffer_end) begin
            push_op.kind   = crcdf_pkg::OP_REPORT;
            push_op.status = crcdf_pkg::ST_TRUNC_PAY;
            rec_end        = 1'b1;
          end else begin
            push_op.kind   = crcdf_pkg::OP_START;
          end
        end else if (buffer_end) begin
          push           = accept;
          push_op.kind   = crcdf_pkg::OP_REPORT;
          push_op.status = crcdf_pkg::ST_TRUNC_HDR;
          rec_end        = 1'b1;
        end
      end
      crcdf_pkg::PH_PAYLOAD: begin
        push          = accept;
        push_op.kind  = crcdf_pkg::OP_PAY;
        push_op.data  = data_byte;
        push_op.last  = pay_last;
        push_op.trunc = buffer_end && !pay_last;
        rec_end       = pay_last || buffer_end;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= 1'b0;
    end else if (cfg.valid) begin
      byte_order <= cfg.data;
    end
  end

  // Record state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= crcdf_pkg::PH_HEADER;
      header_count    <= '0;
      length_word     <= '0;
      flags_byte      <= '0;
      expected_crc    <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (rec_end) begin
        header_count    <= '0;
        length_word     <= '0;
        flags_byte      <= '0;
        expected_crc    <= '0;
        bytes_remaining <= '0;
      end else if (phase == crcdf_pkg::PH_HEADER) begin
        header_count <= hdr_done ? '0 : idx + 1'b1;
        length_word  <= len_new;
        flags_byte   <= flags_new;
        expected_crc <= crc_new;
        if (hdr_done) begin
          bytes_remaining <= len_new;
        end
      end else begin
        bytes_remaining <= bytes_remaining - 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/crcdf_back.sv =====
// Back of the deframer: runs the CRC over payload bytes, forms results and
// holds them in the output register. Depends on crcdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcdf_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crcdf_pkg::op_t head_op,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,
  output logic [1:0]       m_tuser
);

  logic [31:0]         running_crc;
  logic [31:0]         expected_crc;
  logic [31:0]         length_word;
  logic [7:0]          flags_byte;
  logic [31:0]         crc_upd;
  logic                out_free;
  logic                emit;
  logic                has_payload;
  logic                record_done;
  logic [7:0]          payload_byte;
  crcdf_pkg::status_t  status;
  logic [7:0]          res_flags;
  logic [31:0]         res_length;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = head_valid && out_free;
  assign crc_upd  = crcdf_pkg::crc_byte(running_crc, head_op.data);
  assign emit     = pop && (head_op.kind != crcdf_pkg::OP_START);

  // Result fields for the operation at the queue head.
  always_comb begin
    has_payload  = 1'b0;
    record_done  = 1'b0;
    payload_byte = '0;
    status       = crcdf_pkg::ST_OK;
    res_flags    = '0;
    res_length   = '0;
    case (head_op.kind)
      crcdf_pkg::OP_REPORT: begin
        record_done = 1'b1;
        status      = head_op.status;
        res_flags   = head_op.flags;
        res_length  = head_op.length;
      end
      crcdf_pkg::OP_PAY: begin
        has_payload  = 1'b1;
        payload_byte = head_op.data;
        if (head_op.last) begin
          record_done = 1'b1;
          status      = ((crc_upd ^ crcdf_pkg::CRC_INIT) == expected_crc) ?
                        crcdf_pkg::ST_OK : crcdf_pkg::ST_BAD_CRC;
          res_flags   = flags_byte;
          res_length  = length_word;
        end else if (head_op.trunc) begin
          record_done = 1'b1;
          status      = crcdf_pkg::ST_TRUNC_PAY;
          res_flags   = flags_byte;
          res_length  = length_word;
        end
      end
      default: begin
        has_payload = 1'b0;
      end
    endcase
  end

  // CRC and record context.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crcdf_pkg::CRC_INIT;
    end else if (pop) begin
      if (head_op.kind == crcdf_pkg::OP_START) begin
        running_crc <= crcdf_pkg::CRC_INIT;
      end else if (head_op.kind == crcdf_pkg::OP_PAY) begin
        running_crc <= (head_op.last || head_op.trunc) ? crcdf_pkg::CRC_INIT : crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.kind == crcdf_pkg::OP_START) begin
      expected_crc <= head_op.crc;
      length_word  <= head_op.length;
      flags_byte   <= head_op.flags;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {6'd0, res_length, res_flags, status, payload_byte};
      m_tuser <= {record_done, has_payload};
    end
  end

endmodule

`default_nettype wire

// ===== sv/crc_block_deframer.sv =====
// Bytes go from the front through the operation queue to the back's output register.
// Throughput: one byte per cycle; s_tready falls only when the operation queue is full.
// A header byte that finishes nothing produces no result item.
// Reset (rst, synchronous) empties the queue and output register, clears the record
// state, sets the running CRC to all ones and byte_order to little endian.
`timescale 1ns / 1ps
`default_nettype none

module crc_block_deframer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: byte_order (bit 0).
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // Input bytes.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
  input  wire logic        s_tlast,   // buffer_end
  // Result items.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // payload_byte [7:0], record_status [9:8],
                                      // record_flags [17:10], record_length [49:18], zeros
  output logic [1:0]       m_tuser    // has_payload [0], record_done [1]
);

  crcdf_pkg::cfg_t cfg;
  crcdf_pkg::op_t  push_op;
  crcdf_pkg::op_t  head_op;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.data  = cfg_data;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  crcdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .data_byte  (s_tdata),
    .buffer_end (s_tlast),
    .push       (push),
    .push_op    (push_op)
  );

  crcdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .head_op   (head_op),
    .not_empty (q_valid)
  );

  crcdf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_op    (head_op),
    .head_valid (q_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== sv/crcdf_checker.sv =====
// Port-level checks of the CRC block deframer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crcdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // A stalled item keeps its contents.
  `ASSERT_CHK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")

  // Every item carries a payload byte or a record report.
  `ASSERT_CHK(a_out_kind, clk, rst, m_tvalid |-> (m_tuser[0] || m_tuser[1]), "empty item")

  // Without a payload byte the byte lane reads zero.
  `ASSERT_CHK(a_pay_zero, clk, rst, m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0, "payload byte not zero")

  // Without a record report the status fields and padding read zero.
  `ASSERT_CHK(a_rep_zero, clk, rst, m_tvalid && !m_tuser[1] |-> m_tdata[55:8] == 48'd0, "status fields not zero")

  // Reset empties the output register.
  `ASSERT_ANY(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind crc_block_deframer crcdf_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
